/* rtl/core/roc_pkg.sv */
// ----------------------------------------------------------------------------
// roc_pkg
// Shared types, constants and the divider step for the RGBA over compositor.
// ----------------------------------------------------------------------------
package roc_pkg;

    // Field widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned LANES   = 3;
    localparam int unsigned NUM_W   = 24;
    localparam int unsigned AC_W    = 16;
    localparam int unsigned PROD_W  = 16;
    localparam int unsigned QUOT_W  = 8;

    // Default queue depth between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Arithmetic constants
    localparam logic [CHAN_W-1:0] CH_MAX     = 8'd255;
    localparam logic [AC_W-1:0]   FULL_COVER = 16'd65025;
    localparam logic [CHAN_W-1:0] ROUND      = 8'd127;

    // Request classes
    localparam logic [1:0] KIND_LOWER = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_MIX   = 2'd2;

    // Colour lanes: index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [CHAN_W-1:0]            alpha;
        logic [LANES-1:0][CHAN_W-1:0] colour;
    } pixel_t;

    // One queued request: numerators, coverage and the pass-through pixel
    typedef struct packed {
        logic                        mix;
        logic [AC_W-1:0]             ac;
        logic [LANES-1:0][NUM_W-1:0] num;
        pixel_t                      pixel;
    } job_t;

    // One divider stage: running remainders and quotient bits
    typedef struct packed {
        logic                         mix;
        logic [AC_W-1:0]              ac;
        logic [LANES-1:0][NUM_W-1:0]  rem;
        logic [LANES-1:0][QUOT_W-1:0] quot;
        pixel_t                       pixel;
    } div_stage_t;

    // Restoring division, one quotient bit for all three lanes
    function automatic div_stage_t div_step(input div_stage_t s, input logic [2:0] sh);
        div_stage_t r;
        logic [NUM_W-1:0] d;
        r = s;
        d = {{(NUM_W-AC_W){1'b0}}, s.ac} << sh;
        for (int k = 0; k < LANES; k++)
        begin
            if (s.rem[k] >= d)
            begin
                r.rem[k]      = s.rem[k] - d;
                r.quot[k][sh] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/roc_pair_if.sv */
// ----------------------------------------------------------------------------
// roc_pair_if
// Request channel carrying one upper and one lower straight-alpha pixel.
// ----------------------------------------------------------------------------
interface roc_pair_if;
    logic                        valid;
    logic                        ready;
    logic [roc_pkg::CHAN_W-1:0]  upper_red;
    logic [roc_pkg::CHAN_W-1:0]  upper_green;
    logic [roc_pkg::CHAN_W-1:0]  upper_blue;
    logic [roc_pkg::CHAN_W-1:0]  upper_alpha;
    logic [roc_pkg::CHAN_W-1:0]  lower_red;
    logic [roc_pkg::CHAN_W-1:0]  lower_green;
    logic [roc_pkg::CHAN_W-1:0]  lower_blue;
    logic [roc_pkg::CHAN_W-1:0]  lower_alpha;

    modport source
    (
        output valid, upper_red, upper_green, upper_blue, upper_alpha,
        output lower_red, lower_green, lower_blue, lower_alpha,
        input  ready
    );

    modport sink
    (
        input  valid, upper_red, upper_green, upper_blue, upper_alpha,
        input  lower_red, lower_green, lower_blue, lower_alpha,
        output ready
    );
endinterface

/* rtl/core/roc_pixel_if.sv */
// ----------------------------------------------------------------------------
// roc_pixel_if
// Result channel carrying one composited pixel.
// ----------------------------------------------------------------------------
interface roc_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [roc_pkg::CHAN_W-1:0]  out_red;
    logic [roc_pkg::CHAN_W-1:0]  out_green;
    logic [roc_pkg::CHAN_W-1:0]  out_blue;
    logic [roc_pkg::CHAN_W-1:0]  out_alpha;

    modport source
    (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );

    modport sink
    (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

/* rtl/core/roc_front.sv */
// ----------------------------------------------------------------------------
// roc_front
// Accepts pixel pairs, classifies them and forms coverage and numerators.
// ----------------------------------------------------------------------------
module roc_front #(
    parameter int unsigned QUEUE_DEPTH = roc_pkg::QUEUE_DEPTH,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    roc_pair_if.sink           pairs,
    input  logic [CNT_W-1:0]   queue_count,
    output logic               push,
    output roc_pkg::job_t      push_job
);

    localparam int unsigned SUM_W = CNT_W + 2;

    // Stage 1 registers
    logic                                              s1_valid_reg;
    logic                                              s1_valid_next;
    logic [1:0]                                        s1_kind_reg;
    logic [1:0]                                        s1_kind_next;
    roc_pkg::pixel_t                                   s1_upper_reg;
    roc_pkg::pixel_t                                   s1_upper_next;
    roc_pkg::pixel_t                                   s1_lower_reg;
    roc_pkg::pixel_t                                   s1_lower_next;
    logic [roc_pkg::PROD_W-1:0]                        s1_na_ab_reg;
    logic [roc_pkg::PROD_W-1:0]                        s1_na_ab_next;
    logic [roc_pkg::PROD_W-1:0]                        s1_na_nb_reg;
    logic [roc_pkg::PROD_W-1:0]                        s1_na_nb_next;
    logic [roc_pkg::LANES-1:0][roc_pkg::PROD_W-1:0]    s1_a_up_reg;
    logic [roc_pkg::LANES-1:0][roc_pkg::PROD_W-1:0]    s1_a_up_next;

    // Stage 2 registers
    logic                                              s2_valid_reg;
    roc_pkg::job_t                                     s2_job_reg;
    roc_pkg::job_t                                     s2_job_next;

    logic [roc_pkg::CHAN_W-1:0]                        na;
    logic [roc_pkg::CHAN_W-1:0]                        nb;
    logic [SUM_W-1:0]                                  occupancy;
    logic [roc_pkg::AC_W-1:0]                          ac;
    logic [roc_pkg::AC_W:0]                            ac_rnd;
    logic [roc_pkg::AC_W:0]                            alpha_q;

    // Credit: queue entries plus requests still in the two stages
    assign occupancy = SUM_W'(queue_count) + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg);
    assign pairs.ready = (occupancy < SUM_W'(QUEUE_DEPTH));
    assign s1_valid_next = pairs.valid && pairs.ready;

    // Stage 1: classify and form the first products
    always_comb
    begin
        na = roc_pkg::CH_MAX - pairs.upper_alpha;
        nb = roc_pkg::CH_MAX - pairs.lower_alpha;

        s1_upper_next.alpha     = pairs.upper_alpha;
        s1_upper_next.colour[0] = pairs.upper_red;
        s1_upper_next.colour[1] = pairs.upper_green;
        s1_upper_next.colour[2] = pairs.upper_blue;
        s1_lower_next.alpha     = pairs.lower_alpha;
        s1_lower_next.colour[0] = pairs.lower_red;
        s1_lower_next.colour[1] = pairs.lower_green;
        s1_lower_next.colour[2] = pairs.lower_blue;

        if (pairs.upper_alpha == '0)
            s1_kind_next = roc_pkg::KIND_LOWER;
        else if (pairs.lower_alpha == '0)
            s1_kind_next = roc_pkg::KIND_UPPER;
        else
            s1_kind_next = roc_pkg::KIND_MIX;

        s1_na_ab_next = roc_pkg::PROD_W'(na) * roc_pkg::PROD_W'(pairs.lower_alpha);
        s1_na_nb_next = roc_pkg::PROD_W'(na) * roc_pkg::PROD_W'(nb);
        for (int k = 0; k < roc_pkg::LANES; k++)
        begin
            s1_a_up_next[k] = roc_pkg::PROD_W'(pairs.upper_alpha)
                            * roc_pkg::PROD_W'(s1_upper_next.colour[k]);
        end
    end

    // Stage 2: coverage, output alpha and colour numerators
    always_comb
    begin
        ac      = roc_pkg::FULL_COVER - s1_na_nb_reg;
        ac_rnd  = (roc_pkg::AC_W+1)'(ac) + (roc_pkg::AC_W+1)'(roc_pkg::ROUND);
        // divide by 255 through the 257/65536 reciprocal, exact below 65535
        alpha_q = (ac_rnd + (ac_rnd >> 8) + (roc_pkg::AC_W+1)'(1)) >> 8;

        s2_job_next.mix = 1'b0;
        s2_job_next.ac  = ac;
        for (int k = 0; k < roc_pkg::LANES; k++)
        begin
            s2_job_next.num[k] = roc_pkg::NUM_W'(s1_na_ab_reg)
                                   * roc_pkg::NUM_W'(s1_lower_reg.colour[k])
                               + ({s1_a_up_reg[k], 8'd0} - roc_pkg::NUM_W'(s1_a_up_reg[k]))
                               + roc_pkg::NUM_W'(roc_pkg::ROUND);
        end

        case (s1_kind_reg)
            roc_pkg::KIND_UPPER:
            begin
                s2_job_next.pixel = s1_upper_reg;
            end
            roc_pkg::KIND_MIX:
            begin
                s2_job_next.mix         = 1'b1;
                s2_job_next.pixel       = s1_upper_reg;
                s2_job_next.pixel.alpha = alpha_q[roc_pkg::CHAN_W-1:0];
            end
            default:
            begin
                s2_job_next.pixel = s1_lower_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= s1_kind_next;
        s1_upper_reg <= s1_upper_next;
        s1_lower_reg <= s1_lower_next;
        s1_na_ab_reg <= s1_na_ab_next;
        s1_na_nb_reg <= s1_na_nb_next;
        s1_a_up_reg  <= s1_a_up_next;
        s2_job_reg   <= s2_job_next;
    end

    assign push     = s2_valid_reg;
    assign push_job = s2_job_reg;

endmodule

/* rtl/core/roc_queue.sv */
// ----------------------------------------------------------------------------
// roc_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module roc_queue #(
    parameter int unsigned QUEUE_DEPTH = roc_pkg::QUEUE_DEPTH,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  roc_pkg::job_t      push_job,
    input  logic               pop,
    output roc_pkg::job_t      head,
    output logic               head_valid,
    output logic [CNT_W-1:0]   count
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    roc_pkg::job_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // Pointer wrap and fill level; the front never pushes into a full queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

/* rtl/core/roc_back.sv */
// ----------------------------------------------------------------------------
// roc_back
// Pipelined three-lane divider and output register.
// ----------------------------------------------------------------------------
module roc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  roc_pkg::job_t   head,
    input  logic            head_valid,
    output logic            pop,
    roc_pixel_if.source     pixels
);

    localparam int unsigned STAGES = roc_pkg::QUOT_W;

    roc_pkg::div_stage_t    stage_reg [STAGES];
    roc_pkg::div_stage_t    stage_next [STAGES];
    logic [STAGES-1:0]      stage_valid_reg;
    logic [STAGES-1:0]      stage_valid_next;
    roc_pkg::pixel_t        out_reg;
    roc_pkg::pixel_t        out_next;
    logic                   out_valid_reg;
    roc_pkg::div_stage_t    last_step;
    logic                   advance;

    // The whole pipe moves when the output register is free or being taken
    assign advance = !out_valid_reg || pixels.ready;
    assign pop     = advance && head_valid;

    // Load from the queue head, then one quotient bit per stage, most significant first
    always_comb
    begin
        stage_next[0].mix   = head.mix;
        stage_next[0].ac    = head.ac;
        stage_next[0].rem   = head.num;
        stage_next[0].quot  = '0;
        stage_next[0].pixel = head.pixel;
        stage_valid_next[0] = head_valid;
        for (int j = 1; j < STAGES; j++)
        begin
            stage_next[j]       = roc_pkg::div_step(stage_reg[j-1], 3'(STAGES - j));
            stage_valid_next[j] = stage_valid_reg[j-1];
        end
    end

    // Final bit and pixel assembly
    always_comb
    begin
        last_step = roc_pkg::div_step(stage_reg[STAGES-1], 3'd0);
        out_next  = last_step.pixel;
        if (last_step.mix)
            out_next.colour = last_step.quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= stage_valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j < STAGES; j++)
                stage_reg[j] <= stage_next[j];
            out_reg <= out_next;
        end
    end

    assign pixels.valid     = out_valid_reg;
    assign pixels.out_red   = out_reg.colour[0];
    assign pixels.out_green = out_reg.colour[1];
    assign pixels.out_blue  = out_reg.colour[2];
    assign pixels.out_alpha = out_reg.alpha;

endmodule

/* rtl/core/rgba_over_compositor.sv */
// ----------------------------------------------------------------------------
// rgba_over_compositor
// Straight-alpha RGBA8888 "over" compositing, one pixel pair per clock while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   pairs  (sink)   : one request is an upper and a lower 8-bit RGBA pixel.
//   pixels (source) : one composited pixel per request, in request order.
//   Transparent upper pixel gives the lower pixel; transparent lower pixel
//   gives the upper pixel; otherwise coverage and colours are mixed with
//   rounding.
//   Throughput: one request per cycle while pixels.ready stays high.
//   With the queue empty, a request passes two front stages, one queue slot,
//   eight divider stages (one quotient bit each) and the output register,
//   the first loaded on the accepting edge.
//   When the receiver stalls the divider pipe holds; the front keeps taking
//   requests until the queue (QUEUE_DEPTH entries, counting those still in
//   the front stages) is full, then pairs.ready drops. QUEUE_DEPTH of 4 or
//   more keeps the full rate.
//   Reset empties the queue and the pipe; no request is lost or repeated.
// ----------------------------------------------------------------------------
module rgba_over_compositor #(
    parameter int unsigned QUEUE_DEPTH = roc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    roc_pair_if.sink    pairs,
    roc_pixel_if.source pixels
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               push;
    roc_pkg::job_t      push_job;
    logic               pop;
    roc_pkg::job_t      head;
    logic               head_valid;
    logic [CNT_W-1:0]   queue_count;

    roc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pairs       (pairs),
        .queue_count (queue_count),
        .push        (push),
        .push_job    (push_job)
    );

    roc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_job    (push_job),
        .pop         (pop),
        .head        (head),
        .head_valid  (head_valid),
        .count       (queue_count)
    );

    roc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .pixels      (pixels)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the RGBA over compositor against a behavioural predictor of the
// straight-alpha "over" rule. A short directed set comes first, then random
// pixel pairs. Both channels stall in random bursts, and the tail of the run
// streams at full rate. Every composited pixel is compared in order with the
// prediction made when its request was accepted.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned RANDOM_PAIRS   = 1832;
    localparam int unsigned TAIL_PAIRS     = 250;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    typedef logic [7:0] chan_t;

    typedef struct packed {
        chan_t upper_red;
        chan_t upper_green;
        chan_t upper_blue;
        chan_t upper_alpha;
        chan_t lower_red;
        chan_t lower_green;
        chan_t lower_blue;
        chan_t lower_alpha;
    } pixel_pair_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } rgba_t;

    logic clk = 1'b0;
    logic rst_n;

    roc_pair_if  pairs_bus ();
    roc_pixel_if pixels_bus ();

    rgba_over_compositor dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pairs  (pairs_bus),
        .pixels (pixels_bus)
    );

    always #4 clk = ~clk;

    pixel_pair_t pending_pairs[$];
    rgba_t       expected_pixels[$];
    pixel_pair_t on_wire;

    int unsigned directed_pairs = 0;
    int unsigned accepted_pairs = 0;
    int unsigned checked_pixels = 0;
    int unsigned upper_clear    = 0;
    int unsigned lower_clear    = 0;
    int unsigned blended        = 0;
    int unsigned fail_count     = 0;
    int unsigned src_gap        = 0;
    int unsigned sink_gap       = 0;
    int unsigned idle_cycles    = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // One colour channel of the alpha-weighted mix, rounded
    function automatic chan_t blend_channel(int unsigned a, int unsigned ab,
                                            int unsigned ac, chan_t up, chan_t lo);
        int unsigned num;
        num = (255 - a) * lo * ab + a * up * 255 + 127;
        return chan_t'(num / ac);
    endfunction

    function automatic rgba_t compose_over(pixel_pair_t p);
        rgba_t       r;
        int unsigned a;
        int unsigned ab;
        int unsigned ac;
        a  = p.upper_alpha;
        ab = p.lower_alpha;
        if (a == 0)
        begin
            r = '{p.lower_red, p.lower_green, p.lower_blue, p.lower_alpha};
        end
        else if (ab == 0)
        begin
            r = '{p.upper_red, p.upper_green, p.upper_blue, p.upper_alpha};
        end
        else
        begin
            ac      = 65025 - (255 - a) * (255 - ab);
            r.red   = blend_channel(a, ab, ac, p.upper_red,   p.lower_red);
            r.green = blend_channel(a, ab, ac, p.upper_green, p.lower_green);
            r.blue  = blend_channel(a, ab, ac, p.upper_blue,  p.lower_blue);
            r.alpha = chan_t'((ac + 127) / 255);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_pair(chan_t ur, chan_t ug, chan_t ub, chan_t ua,
                                     chan_t lr, chan_t lg, chan_t lb, chan_t la);
        pending_pairs.push_back('{ur, ug, ub, ua, lr, lg, lb, la});
    endfunction

    // Alphas lean towards the edges so both pass-through paths stay busy
    function automatic chan_t pick_alpha();
        case ($urandom_range(0, 15))
            0, 1:    return 8'd0;
            2:       return 8'd1;
            3, 4:    return 8'd255;
            5:       return 8'd254;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic chan_t pick_colour();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Quiet stretches mid-run and a full-rate tail
    function automatic logic no_idling();
        return (pending_pairs.size() < TAIL_PAIRS) || ((accepted_pairs / 150) % 4 == 3);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_bus.valid       <= 1'b0;
            pairs_bus.upper_red   <= '0;
            pairs_bus.upper_green <= '0;
            pairs_bus.upper_blue  <= '0;
            pairs_bus.upper_alpha <= '0;
            pairs_bus.lower_red   <= '0;
            pairs_bus.lower_green <= '0;
            pairs_bus.lower_blue  <= '0;
            pairs_bus.lower_alpha <= '0;
        end
        else if (!(pairs_bus.valid && !pairs_bus.ready))
        begin
            // Request taken: record its prediction
            if (pairs_bus.valid)
            begin
                expected_pixels.push_back(compose_over(on_wire));
                accepted_pairs++;
                if (on_wire.upper_alpha == 0)
                    upper_clear++;
                else if (on_wire.lower_alpha == 0)
                    lower_clear++;
                else
                    blended++;
            end

            // Next request, or an idle burst
            if (src_gap > 0)
            begin
                src_gap--;
                pairs_bus.valid <= 1'b0;
            end
            else if (pending_pairs.size() != 0 && !no_idling() && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(1, 12) - 1;
                pairs_bus.valid <= 1'b0;
            end
            else if (pending_pairs.size() != 0)
            begin
                on_wire = pending_pairs.pop_front();
                pairs_bus.valid       <= 1'b1;
                pairs_bus.upper_red   <= on_wire.upper_red;
                pairs_bus.upper_green <= on_wire.upper_green;
                pairs_bus.upper_blue  <= on_wire.upper_blue;
                pairs_bus.upper_alpha <= on_wire.upper_alpha;
                pairs_bus.lower_red   <= on_wire.lower_red;
                pairs_bus.lower_green <= on_wire.lower_green;
                pairs_bus.lower_blue  <= on_wire.lower_blue;
                pairs_bus.lower_alpha <= on_wire.lower_alpha;
            end
            else
            begin
                pairs_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_bus.ready <= 1'b0;
        end
        else
        begin
            if (pixels_bus.valid && pixels_bus.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel with no request outstanding: r %0d g %0d b %0d a %0d",
                           pixels_bus.out_red, pixels_bus.out_green,
                           pixels_bus.out_blue, pixels_bus.out_alpha);
                    fail_count++;
                end
                else
                begin
                    rgba_t want;
                    want = expected_pixels.pop_front();
                    checked_pixels++;
                    if (pixels_bus.out_red !== want.red)
                    begin
                        $error("out_red: expected %0d, got %0d", want.red, pixels_bus.out_red);
                        fail_count++;
                    end
                    if (pixels_bus.out_green !== want.green)
                    begin
                        $error("out_green: expected %0d, got %0d",
                               want.green, pixels_bus.out_green);
                        fail_count++;
                    end
                    if (pixels_bus.out_blue !== want.blue)
                    begin
                        $error("out_blue: expected %0d, got %0d",
                               want.blue, pixels_bus.out_blue);
                        fail_count++;
                    end
                    if (pixels_bus.out_alpha !== want.alpha)
                    begin
                        $error("out_alpha: expected %0d, got %0d",
                               want.alpha, pixels_bus.out_alpha);
                        fail_count++;
                    end
                end
            end

            // Receiver back-pressure in bursts
            if (sink_gap > 0)
            begin
                sink_gap--;
                pixels_bus.ready <= 1'b0;
            end
            else if (!no_idling() && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(1, 12) - 1;
                pixels_bus.ready <= 1'b0;
            end
            else
            begin
                pixels_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no request or pixel moving
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pairs_bus.valid && pairs_bus.ready) || (pixels_bus.valid && pixels_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        pixel_pair_t p;

        rst_n = 1'b0;

        // Transparent upper: lower passes, even when it is transparent too
        add_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
        add_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255);
        add_pair(8'd17,  8'd99,  8'd200, 8'd0,   8'd201, 8'd3,   8'd77,  8'd0);
        add_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd12,  8'd34,  8'd56,  8'd128);
        // Transparent lower: upper is copied
        add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
        add_pair(8'd1,   8'd128, 8'd254, 8'd1,   8'd90,  8'd80,  8'd70,  8'd0);
        add_pair(8'd200, 8'd100, 8'd50,  8'd200, 8'd0,   8'd0,   8'd0,   8'd0);
        // Opaque corners and minimum coverage
        add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        add_pair(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        add_pair(8'd255, 8'd255, 8'd255, 8'd1,   8'd0,   8'd0,   8'd0,   8'd1);
        add_pair(8'd0,   8'd255, 8'd0,   8'd1,   8'd255, 8'd0,   8'd255, 8'd1);
        add_pair(8'd255, 8'd0,   8'd128, 8'd1,   8'd0,   8'd255, 8'd127, 8'd255);
        add_pair(8'd0,   8'd255, 8'd127, 8'd255, 8'd255, 8'd0,   8'd128, 8'd1);
        // Half coverage and alternating bit patterns
        add_pair(8'd0,   8'd0,   8'd0,   8'd128, 8'd255, 8'd255, 8'd255, 8'd255);
        add_pair(8'd255, 8'd255, 8'd255, 8'd128, 8'd0,   8'd0,   8'd0,   8'd128);
        add_pair(8'hAA,  8'h55,  8'hAA,  8'h55,  8'h55,  8'hAA,  8'h55,  8'hAA);
        add_pair(8'h55,  8'hAA,  8'h55,  8'hAA,  8'hAA,  8'h55,  8'hAA,  8'h55);
        add_pair(8'd254, 8'd1,   8'd254, 8'd254, 8'd1,   8'd254, 8'd1,   8'd254);
        directed_pairs = pending_pairs.size();

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            p.upper_red   = pick_colour();
            p.upper_green = pick_colour();
            p.upper_blue  = pick_colour();
            p.upper_alpha = pick_alpha();
            p.lower_red   = pick_colour();
            p.lower_green = pick_colour();
            p.lower_blue  = pick_colour();
            p.lower_alpha = pick_alpha();
            pending_pairs.push_back(p);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every pixel to come back
        do
            @(posedge clk);
        while (pending_pairs.size() != 0 || pairs_bus.valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Composited %0d pixel pairs (%0d directed): %0d clear upper, %0d clear lower,",
                 accepted_pairs, directed_pairs, upper_clear, lower_clear);
        $display("  %0d blended; %0d pixels checked, %0d mismatches.",
                 blended, checked_pixels, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
